// ----- hw/rtl/fixed_slot_free_list_allocator_assert.svh -----
// Assertion macros for the slot allocator. The enclosing module provides clk and rst_n.
`ifndef FIXED_SLOT_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define FIXED_SLOT_FREE_LIST_ALLOCATOR_ASSERT_SVH

// Checked at every clock edge outside reset.
`define FSFLA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define FSFLA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/fsfla_pkg.sv -----
`default_nettype none

package fsfla_pkg;

  localparam int SLOTS      = 4096;
  localparam int GHOST_BITS = 32;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int CNT_W      = SLOT_W + 1;

  // One memory entry: link valid, link, ghost word.
  localparam int ENTRY_W = 1 + SLOT_W + GHOST_BITS;

  localparam int IN_TDATA_W  = ((SLOT_W + GHOST_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_W = SLOT_W + 1 + GHOST_BITS + 1 + 2 + CNT_W + CNT_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_RANGE     = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_INITIAL_RESERVE = 2'd0,
    REG_GROWTH_STEP     = 2'd1,
    REG_MAX_SLOTS       = 2'd2
  } reg_idx_t;

endpackage

`default_nettype wire

// ----- hw/rtl/fsfla_ram.sv -----
`default_nettype none

module fsfla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/fixed_slot_free_list_allocator.sv -----
`default_nettype none

// Fixed-slot allocator with a last-in-first-out free list kept in one on-chip
// memory (link and ghost word per slot). Accepting a request in S_IDLE
// issues the read of the memory entry at the free-list head; S_EXEC, which
// stalls while an untaken result sits in the result register, then applies
// the update, writes the entry of a freed slot and loads the result register.
// A new request is accepted while a result waits there, but only after the
// last one has left S_EXEC. The memory needs no clearing after reset: an
// entry is only read after a free request has written it.
module fixed_slot_free_list_allocator (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // Request channel.
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // [11:0] slot_index, [43:12] ghost_in, upper bits zero.
  input  wire logic [fsfla_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [0] kind: 0 allocate, 1 free.
  input  wire logic                                in_tuser,
  // Result channel.
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // [11:0] result_slot, [12] from_free_list, [44:13] ghost_out, [45] grew,
  // [47:46] status, [60:48] free_total, [73:61] live_total, upper bits zero.
  output logic      [fsfla_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // Configuration port.
  input  wire logic                                cfg_psel,
  input  wire logic                                cfg_penable,
  input  wire logic                                cfg_pwrite,
  input  wire logic [fsfla_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  wire logic [fsfla_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic      [fsfla_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                                     cfg_pready
);

  import fsfla_pkg::*;

  `include "fixed_slot_free_list_allocator_assert.svh"

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [CNT_W-1:0] initial_reserve_r;
  logic [CNT_W-1:0] growth_step_r;
  logic [CNT_W-1:0] max_slots_r;

  // Allocator state.
  logic              head_valid_r, head_valid_nxt;
  logic [SLOT_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0]  high_water_r, high_water_nxt;
  logic [CNT_W-1:0]  reserved_r, reserved_nxt;
  logic [CNT_W-1:0]  tally_r, tally_nxt;

  // Captured request.
  kind_t               kind_r;
  logic [SLOT_W-1:0]   idx_r;
  logic [GHOST_BITS-1:0] ghost_r;
  logic                pop_r;

  // Result register.
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  // Memory port.
  logic               ram_we;
  logic               ram_re;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;

  logic in_acc;
  logic exec_go;
  logic cfg_wr;
  logic [1:0] cfg_idx;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign exec_go    = (state_r == S_EXEC) && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[3:2];

  always_comb begin
    case (cfg_idx)
      REG_INITIAL_RESERVE: cfg_prdata = CFG_DATA_W'(initial_reserve_r);
      REG_GROWTH_STEP:     cfg_prdata = CFG_DATA_W'(growth_step_r);
      REG_MAX_SLOTS:       cfg_prdata = CFG_DATA_W'(max_slots_r);
      default:             cfg_prdata = '0;
    endcase
  end

  // The head only changes in the execute cycle, so the read issued at accept
  // time always sees the current head.
  assign ram_re = in_acc && (kind_t'(in_tuser) == KIND_ALLOC) && head_valid_r;

  fsfla_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  logic [CNT_W-1:0]      limit;
  logic [CNT_W:0]        grown;
  logic [SLOT_W-1:0]     res_slot;
  logic                  res_ffl;
  logic [GHOST_BITS-1:0] res_ghost;
  logic                  res_grew;
  status_t               res_status;
  logic [CNT_W-1:0]      live;

  always_comb begin
    head_valid_nxt = head_valid_r;
    head_nxt       = head_r;
    high_water_nxt = high_water_r;
    reserved_nxt   = reserved_r;
    tally_nxt      = tally_r;
    res_slot       = '0;
    res_ffl        = 1'b0;
    res_ghost      = '0;
    res_grew       = 1'b0;
    res_status     = ST_OK;
    ram_we         = 1'b0;
    ram_wdata      = {head_valid_r, head_r, ghost_r};
    limit          = (max_slots_r < CNT_W'(SLOTS)) ? max_slots_r : CNT_W'(SLOTS);
    grown          = {1'b0, reserved_r} + {1'b0, growth_step_r};

    if (kind_r == KIND_ALLOC) begin
      if (pop_r) begin
        res_slot       = head_r;
        res_ffl        = 1'b1;
        res_ghost      = ram_rdata[GHOST_BITS-1:0];
        head_valid_nxt = ram_rdata[ENTRY_W-1];
        head_nxt       = ram_rdata[GHOST_BITS +: SLOT_W];
        if (tally_r != '0) begin
          tally_nxt = tally_r - 1'b1;
        end
      end else if (high_water_r >= limit) begin
        res_status = ST_EXHAUSTED;
      end else begin
        if (reserved_r <= high_water_r) begin
          reserved_nxt = (grown > (CNT_W+1)'(SLOTS)) ? CNT_W'(SLOTS) : grown[CNT_W-1:0];
          res_grew     = 1'b1;
        end
        res_slot       = high_water_r[SLOT_W-1:0];
        high_water_nxt = high_water_r + 1'b1;
      end
    end else begin
      res_slot = idx_r;
      if ({1'b0, idx_r} >= high_water_r) begin
        res_status = ST_RANGE;
      end else begin
        ram_we         = exec_go;
        head_valid_nxt = 1'b1;
        head_nxt       = idx_r;
        if (tally_r < CNT_W'(SLOTS)) begin
          tally_nxt = tally_r + 1'b1;
        end
      end
    end

    live = (high_water_nxt > tally_nxt) ? (high_water_nxt - tally_nxt) : '0;
    out_data_nxt = OUT_TDATA_W'({live, tally_nxt, res_status, res_grew,
                                 res_ghost, res_ffl, res_slot});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= S_IDLE;
      out_valid_r       <= 1'b0;
      initial_reserve_r <= CNT_W'(64);
      growth_step_r     <= CNT_W'(64);
      max_slots_r       <= CNT_W'(SLOTS);
      head_valid_r      <= 1'b0;
      head_r            <= '0;
      high_water_r      <= '0;
      reserved_r        <= CNT_W'(64);
      tally_r           <= '0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec_go) begin
            state_r      <= S_IDLE;
            out_valid_r  <= 1'b1;
            out_data_r   <= out_data_nxt;
            head_valid_r <= head_valid_nxt;
            head_r       <= head_nxt;
            high_water_r <= high_water_nxt;
            reserved_r   <= reserved_nxt;
            tally_r      <= tally_nxt;
          end
        end
        default: state_r <= S_IDLE;
      endcase

      // Configuration is to be written only while no request is in flight; the block itself does not enforce this.
      if (cfg_wr) begin
        case (cfg_idx)
          REG_INITIAL_RESERVE: begin
            initial_reserve_r <= cfg_pwdata[CNT_W-1:0];
            if (high_water_r == '0) begin
              reserved_r <= cfg_pwdata[CNT_W-1:0];
            end
          end
          REG_GROWTH_STEP: growth_step_r <= cfg_pwdata[CNT_W-1:0];
          REG_MAX_SLOTS:   max_slots_r   <= cfg_pwdata[CNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r  <= kind_t'(in_tuser);
      idx_r   <= in_tdata[SLOT_W-1:0];
      ghost_r <= in_tdata[SLOT_W +: GHOST_BITS];
      pop_r   <= (kind_t'(in_tuser) == KIND_ALLOC) && head_valid_r;
    end
  end

  `FSFLA_ASSERT(a_accept_to_exec, in_acc |=> (state_r == S_EXEC), "request not executed")
  `FSFLA_ASSERT(a_result_from_exec, $rose(out_valid_r) |-> $past(state_r == S_EXEC),
                "result appeared without an execute cycle")
  `FSFLA_ASSERT_ALWAYS(a_mark_bounded, !rst_n || (high_water_r <= CNT_W'(SLOTS)),
                       "high-water mark above slot count")
  `FSFLA_ASSERT(a_pop_has_head, (state_r == S_EXEC && kind_r == KIND_ALLOC && pop_r)
                |-> head_valid_r, "pop from an empty free list")

endmodule

`default_nettype wire
